/* rtl/s3ls_pkg.sv */
// ----------------------------------------------------------------------------
// s3ls_pkg
// Shared constants for the 3x3 linear system solver.
// ----------------------------------------------------------------------------
package s3ls_pkg;

	// pivot threshold register
	localparam int                   EPS_WIDTH = 31;
	localparam logic [EPS_WIDTH-1:0] EPS_RESET = 31'd16;

endpackage

/* rtl/s3ls_if.sv */
// ----------------------------------------------------------------------------
// s3ls_if
// Valid/ready channels for the solver: system requests in, solutions out.
// ----------------------------------------------------------------------------
interface s3ls_in_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] m00;
	logic signed [DATA_WIDTH-1:0] m01;
	logic signed [DATA_WIDTH-1:0] m02;
	logic signed [DATA_WIDTH-1:0] m10;
	logic signed [DATA_WIDTH-1:0] m11;
	logic signed [DATA_WIDTH-1:0] m12;
	logic signed [DATA_WIDTH-1:0] m20;
	logic signed [DATA_WIDTH-1:0] m21;
	logic signed [DATA_WIDTH-1:0] m22;
	logic signed [DATA_WIDTH-1:0] rhs_0;
	logic signed [DATA_WIDTH-1:0] rhs_1;
	logic signed [DATA_WIDTH-1:0] rhs_2;

	modport source (
		output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, rhs_0, rhs_1, rhs_2,
		input  ready
	);
	modport sink (
		input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, rhs_0, rhs_1, rhs_2,
		output ready
	);
endinterface

interface s3ls_out_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] sol_0;
	logic signed [DATA_WIDTH-1:0] sol_1;
	logic signed [DATA_WIDTH-1:0] sol_2;
	logic                         solved;

	modport source (
		output valid, sol_0, sol_1, sol_2, solved,
		input  ready
	);
	modport sink (
		input  valid, sol_0, sol_1, sol_2, solved,
		output ready
	);
endinterface

/* rtl/s3ls_div.sv */
// ----------------------------------------------------------------------------
// s3ls_div
// Pipelined fixed point divider, one quotient bit per stage, round to nearest
// (ties away from zero), saturating.
// ----------------------------------------------------------------------------
module s3ls_div #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [DATA_WIDTH-1:0] num,
	input  logic signed [DATA_WIDTH-1:0] den,
	output logic signed [DATA_WIDTH-1:0] quo
);
	localparam int W  = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int QW = W + F;
	localparam logic [QW:0]  LIM_N = (QW+1)'(1) << (W-1);
	localparam logic [QW:0]  LIM_P = LIM_N - (QW+1)'(1);
	localparam logic [W-1:0] VMAX  = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] VMIN  = {1'b1, {(W-1){1'b0}}};

	function automatic logic [W-1:0] mag(input logic [W-1:0] x);
		return x[W-1] ? W'(-x) : x;
	endfunction

	logic [W-1:0]  den_s [QW+1];
	logic [W-1:0]  rem_s [QW+1];
	logic [QW-1:0] nq_s  [QW+1];
	logic          neg_s [QW+1];
	logic          an_s  [QW+1];
	logic          dz_s  [QW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= mag(den);
			rem_s[0] <= '0;
			nq_s[0]  <= {mag(num), {F{1'b0}}};
			neg_s[0] <= num[W-1] ^ den[W-1];
			an_s[0]  <= num[W-1];
			dz_s[0]  <= (den == '0);
		end
	end

	// restoring steps: dividend bits shift out the top, quotient bits in at the bottom
	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [W:0] sh;
		logic       ge;
		assign sh = {rem_s[k-1], nq_s[k-1][QW-1]};
		assign ge = sh >= {1'b0, den_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? W'(sh - {1'b0, den_s[k-1]}) : sh[W-1:0];
				nq_s[k]  <= {nq_s[k-1][QW-2:0], ge};
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
				an_s[k]  <= an_s[k-1];
				dz_s[k]  <= dz_s[k-1];
			end
		end
	end

	logic [QW:0]  qrnd_s;
	logic         neg_r_s;
	logic         an_r_s;
	logic         dz_r_s;
	logic [W-1:0] quo_s;
	logic [QW:0]  lim;
	logic [QW:0]  m;

	always_ff @(posedge clk) begin
		if (en) begin
			qrnd_s  <= {1'b0, nq_s[QW]} +
				(QW+1)'(rem_s[QW] >= den_s[QW] - rem_s[QW]);
			neg_r_s <= neg_s[QW];
			an_r_s  <= an_s[QW];
			dz_r_s  <= dz_s[QW];
		end
	end

	always_comb begin
		lim = neg_r_s ? LIM_N : LIM_P;
		m   = (qrnd_s > lim) ? lim : qrnd_s;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dz_r_s) begin
				quo_s <= an_r_s ? VMIN : VMAX;
			end else begin
				quo_s <= neg_r_s ? W'(-m[W-1:0]) : m[W-1:0];
			end
		end
	end

	assign quo = quo_s;
endmodule

/* rtl/s3ls_mul.sv */
// ----------------------------------------------------------------------------
// s3ls_mul
// Pipelined fixed point multiplier on half-width partial products, round to
// nearest (ties away from zero), saturating.
// ----------------------------------------------------------------------------
module s3ls_mul #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [DATA_WIDTH-1:0] a,
	input  logic signed [DATA_WIDTH-1:0] b,
	output logic signed [DATA_WIDTH-1:0] prod
);
	localparam int W  = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int HW = (W + 1) / 2;
	localparam int UW = W - HW;
	localparam int PW = 2*W + 1 - F;
	localparam logic [PW-1:0] LIM_N = PW'(1) << (W-1);
	localparam logic [PW-1:0] LIM_P = LIM_N - PW'(1);
	localparam logic [2*W:0]  HALF  = (2*W+1)'(1) << (F-1);

	function automatic logic [W-1:0] mag(input logic [W-1:0] x);
		return x[W-1] ? W'(-x) : x;
	endfunction

	logic [W-1:0]      x_s0, y_s0;
	logic              neg_s0, neg_s1, neg_s2, neg_s3;
	logic [2*HW-1:0]   p00_s1;
	logic [W-1:0]      p01_s1, p10_s1;
	logic [2*UW-1:0]   p11_s1;
	logic [2*W-1:0]    p_s2;
	logic [PW-1:0]     q_s3;
	logic [W-1:0]      prod_s4;
	logic [2*W:0]      rnd;
	logic [PW-1:0]     lim;
	logic [PW-1:0]     m;

	always_comb begin
		rnd = {1'b0, p_s2} + HALF;
		lim = neg_s3 ? LIM_N : LIM_P;
		m   = (q_s3 > lim) ? lim : q_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s0    <= mag(a);
			y_s0    <= mag(b);
			neg_s0  <= a[W-1] ^ b[W-1];
			p00_s1  <= (2*HW)'(x_s0[HW-1:0]) * (2*HW)'(y_s0[HW-1:0]);
			p01_s1  <= W'(x_s0[HW-1:0]) * W'(y_s0[W-1:HW]);
			p10_s1  <= W'(x_s0[W-1:HW]) * W'(y_s0[HW-1:0]);
			p11_s1  <= (2*UW)'(x_s0[W-1:HW]) * (2*UW)'(y_s0[W-1:HW]);
			neg_s1  <= neg_s0;
			p_s2    <= (2*W)'(p00_s1) + ((2*W)'(p01_s1) << HW) +
				((2*W)'(p10_s1) << HW) + ((2*W)'(p11_s1) << (2*HW));
			neg_s2  <= neg_s1;
			q_s3    <= rnd[2*W:F];
			neg_s3  <= neg_s2;
			prod_s4 <= neg_s3 ? W'(-m[W-1:0]) : m[W-1:0];
		end
	end

	assign prod = prod_s4;
endmodule

/* rtl/solve_3x3_linear_system.sv */
// ----------------------------------------------------------------------------
// solve_3x3_linear_system
// Solves A*x = b for one 3x3 fixed point system per request by Gaussian
// elimination with partial pivoting and back-substitution.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one system (m00..m22, rhs_0..rhs_2) per request; out_ch
//   returns sol_0..sol_2 and solved for each request, in order. solved is 0
//   and the solution zero when a pivot magnitude is at or below the
//   threshold written through cfg_wen/cfg_wdata (write only while idle).
//   Throughput: one request per cycle while in_ch.ready is high. Most of
//   the pipeline depth lies in the three chained divider pipelines (one
//   quotient bit per stage).
//   The pipeline advances as one; a two-entry output stage (output register
//   plus skid) lets one more result land while out_ch is stalled, after
//   which in_ch.ready drops until out_ch.ready frees the skid entry.
//   Reset clears all valid bits, empties the output stage and sets the
//   threshold to its default of 16 (2^-12 in Q16.16).
// ----------------------------------------------------------------------------
module solve_3x3_linear_system #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [s3ls_pkg::EPS_WIDTH-1:0]    cfg_wdata,
	s3ls_in_if.sink                           in_ch,
	s3ls_out_if.source                        out_ch
);
	localparam int W   = DATA_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int EW  = s3ls_pkg::EPS_WIDTH;
	localparam int CW  = (W > EW) ? W : EW;
	localparam int QW  = W + F;
	localparam int DL  = QW + 3;
	localparam int ML  = 5;
	localparam int LAT = 10 + 3*DL + 4*ML;

	typedef logic signed [W-1:0] v_t;
	localparam v_t VMAX = {1'b0, {(W-1){1'b1}}};
	localparam v_t VMIN = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic nz0;
		logic nz1;
		logic nz2;
	} fl_t;

	typedef struct packed {
		v_t [3:0] r1;
		v_t [3:0] r2;
		fl_t      fl;
	} cb_t;

	typedef struct packed {
		v_t [3:1] r1;
		v_t [3:1] r2;
		v_t [3:1] q0;
		fl_t      fl;
	} cc_t;

	typedef struct packed {
		v_t [3:1] r2;
		v_t [3:1] q0;
		fl_t      fl;
	} ce_t;

	typedef struct packed {
		v_t       r22;
		v_t       r23;
		v_t       q12;
		v_t       q13;
		v_t [3:1] q0;
		fl_t      fl;
	} cf_t;

	typedef struct packed {
		v_t       q12;
		v_t       q13;
		v_t [3:1] q0;
		fl_t      fl;
	} ch_t;

	typedef struct packed {
		v_t       x2;
		v_t       q13;
		v_t [3:1] q0;
		fl_t      fl;
	} ci_t;

	typedef struct packed {
		v_t  x2;
		v_t  x1;
		v_t  t;
		v_t  q01;
		fl_t fl;
	} bk_t;

	typedef struct packed {
		v_t   sol0;
		v_t   sol1;
		v_t   sol2;
		logic solved;
	} res_t;

	function automatic logic [W-1:0] mag(input logic [W-1:0] x);
		return x[W-1] ? W'(-x) : x;
	endfunction

	function automatic logic near_zero(input logic [W-1:0] x, input logic [EW-1:0] e);
		return CW'(mag(x)) <= CW'(e);
	endfunction

	function automatic v_t sat_sub(input v_t a, input v_t b);
		logic [W:0] d;
		d = {a[W-1], a} - {b[W-1], b};
		if (d[W] != d[W-1]) begin
			return d[W] ? VMIN : VMAX;
		end
		return d[W-1:0];
	endfunction

	// ---------------- control: threshold, valid line, output stage ----------
	logic [EW-1:0]  eps_q;
	logic [LAT-1:0] vld_s;
	logic           en;
	logic           push;
	logic           out_v_q, skid_v_q;
	res_t           out_q, skid_q;
	res_t           res_s11;

	assign en          = !skid_v_q;
	assign push        = vld_s[LAT-1] && en;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= s3ls_pkg::EPS_RESET;
		end else if (cfg_wen) begin
			eps_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], in_ch.valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!skid_v_q) begin
			if (!out_v_q || out_ch.ready) begin
				out_v_q <= push;
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end else if (out_ch.ready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			if (!out_v_q || out_ch.ready) begin
				out_q <= res_s11;
			end else begin
				skid_q <= res_s11;
			end
		end else if (out_ch.ready) begin
			out_q <= skid_q;
		end
	end

	assign out_ch.valid  = out_v_q;
	assign out_ch.sol_0  = out_q.sol0;
	assign out_ch.sol_1  = out_q.sol1;
	assign out_ch.sol_2  = out_q.sol2;
	assign out_ch.solved = out_q.solved;

	// ---------------- s1..s3: capture, first pivot, threshold ---------------
	v_t            rw_s1 [3][4];
	v_t            rw_s2 [3][4];
	v_t            rw_s3 [3][4];
	logic          nz0_s3;
	logic [W-1:0]  ma0, ma1, ma2;

	always_ff @(posedge clk) begin
		if (en) begin
			rw_s1[0][0] <= in_ch.m00;
			rw_s1[0][1] <= in_ch.m01;
			rw_s1[0][2] <= in_ch.m02;
			rw_s1[0][3] <= in_ch.rhs_0;
			rw_s1[1][0] <= in_ch.m10;
			rw_s1[1][1] <= in_ch.m11;
			rw_s1[1][2] <= in_ch.m12;
			rw_s1[1][3] <= in_ch.rhs_1;
			rw_s1[2][0] <= in_ch.m20;
			rw_s1[2][1] <= in_ch.m21;
			rw_s1[2][2] <= in_ch.m22;
			rw_s1[2][3] <= in_ch.rhs_2;
		end
	end

	always_comb begin
		ma0 = mag(rw_s1[0][0]);
		ma1 = mag(rw_s1[1][0]);
		ma2 = mag(rw_s1[2][0]);
	end

	// ties go to row 1, then row 2
	always_ff @(posedge clk) begin
		if (en) begin
			if (ma1 >= ma0 && ma1 >= ma2) begin
				rw_s2[0] <= rw_s1[1];
				rw_s2[1] <= rw_s1[0];
				rw_s2[2] <= rw_s1[2];
			end else if (ma2 >= ma0) begin
				rw_s2[0] <= rw_s1[2];
				rw_s2[1] <= rw_s1[1];
				rw_s2[2] <= rw_s1[0];
			end else begin
				rw_s2 <= rw_s1;
			end
			rw_s3  <= rw_s2;
			nz0_s3 <= near_zero(rw_s2[0][0], eps_q);
		end
	end

	// ---------------- pivot row 0 divide ------------------------------------
	v_t  q0 [1:3];
	cb_t cb_in;
	cb_t cb_s [DL];

	for (genvar j = 1; j <= 3; j++) begin : g_div0
		s3ls_div #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_div (
			.clk (clk),
			.en  (en),
			.num (rw_s3[0][j]),
			.den (rw_s3[0][0]),
			.quo (q0[j])
		);
	end

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			cb_in.r1[j] = rw_s3[1][j];
			cb_in.r2[j] = rw_s3[2][j];
		end
		cb_in.fl.nz0 = nz0_s3;
		cb_in.fl.nz1 = 1'b0;
		cb_in.fl.nz2 = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cb_s[0] <= cb_in;
			for (int k = 1; k < DL; k++) begin
				cb_s[k] <= cb_s[k-1];
			end
		end
	end

	// ---------------- eliminate column 0 ------------------------------------
	v_t  pc1 [1:3];
	v_t  pc2 [1:3];
	cc_t cc_in;
	cc_t cc_s [ML];

	for (genvar j = 1; j <= 3; j++) begin : g_mul0
		s3ls_mul #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_mul1 (
			.clk  (clk),
			.en   (en),
			.a    (cb_s[DL-1].r1[0]),
			.b    (q0[j]),
			.prod (pc1[j])
		);
		s3ls_mul #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_mul2 (
			.clk  (clk),
			.en   (en),
			.a    (cb_s[DL-1].r2[0]),
			.b    (q0[j]),
			.prod (pc2[j])
		);
	end

	always_comb begin
		cc_in.r1 = cb_s[DL-1].r1[3:1];
		cc_in.r2 = cb_s[DL-1].r2[3:1];
		cc_in.q0 = {q0[3], q0[2], q0[1]};
		cc_in.fl = cb_s[DL-1].fl;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cc_s[0] <= cc_in;
			for (int k = 1; k < ML; k++) begin
				cc_s[k] <= cc_s[k-1];
			end
		end
	end

	// ---------------- s5..s7: subtract, second pivot, threshold -------------
	cc_t el_s5, el_s6, el_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 1; j <= 3; j++) begin
				el_s5.r1[j] <= sat_sub(cc_s[ML-1].r1[j], pc1[j]);
				el_s5.r2[j] <= sat_sub(cc_s[ML-1].r2[j], pc2[j]);
			end
			el_s5.q0 <= cc_s[ML-1].q0;
			el_s5.fl <= cc_s[ML-1].fl;

			// swap only on a strictly larger magnitude
			el_s6.q0 <= el_s5.q0;
			el_s6.fl <= el_s5.fl;
			if (mag(el_s5.r2[1]) > mag(el_s5.r1[1])) begin
				el_s6.r1 <= el_s5.r2;
				el_s6.r2 <= el_s5.r1;
			end else begin
				el_s6.r1 <= el_s5.r1;
				el_s6.r2 <= el_s5.r2;
			end

			el_s7.r1     <= el_s6.r1;
			el_s7.r2     <= el_s6.r2;
			el_s7.q0     <= el_s6.q0;
			el_s7.fl.nz0 <= el_s6.fl.nz0;
			el_s7.fl.nz1 <= near_zero(el_s6.r1[1], eps_q);
			el_s7.fl.nz2 <= el_s6.fl.nz2;
		end
	end

	// ---------------- pivot row 1 divide ------------------------------------
	v_t  q12, q13;
	ce_t ce_in;
	ce_t ce_s [DL];

	s3ls_div #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_div12 (
		.clk (clk),
		.en  (en),
		.num (el_s7.r1[2]),
		.den (el_s7.r1[1]),
		.quo (q12)
	);

	s3ls_div #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_div13 (
		.clk (clk),
		.en  (en),
		.num (el_s7.r1[3]),
		.den (el_s7.r1[1]),
		.quo (q13)
	);

	always_comb begin
		ce_in.r2 = el_s7.r2;
		ce_in.q0 = el_s7.q0;
		ce_in.fl = el_s7.fl;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ce_s[0] <= ce_in;
			for (int k = 1; k < DL; k++) begin
				ce_s[k] <= ce_s[k-1];
			end
		end
	end

	// ---------------- eliminate column 1 ------------------------------------
	v_t  pf2, pf3;
	cf_t cf_in;
	cf_t cf_s [ML];

	s3ls_mul #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_mul22 (
		.clk  (clk),
		.en   (en),
		.a    (ce_s[DL-1].r2[1]),
		.b    (q12),
		.prod (pf2)
	);

	s3ls_mul #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_mul23 (
		.clk  (clk),
		.en   (en),
		.a    (ce_s[DL-1].r2[1]),
		.b    (q13),
		.prod (pf3)
	);

	always_comb begin
		cf_in.r22 = ce_s[DL-1].r2[2];
		cf_in.r23 = ce_s[DL-1].r2[3];
		cf_in.q12 = q12;
		cf_in.q13 = q13;
		cf_in.q0  = ce_s[DL-1].q0;
		cf_in.fl  = ce_s[DL-1].fl;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cf_s[0] <= cf_in;
			for (int k = 1; k < ML; k++) begin
				cf_s[k] <= cf_s[k-1];
			end
		end
	end

	// ---------------- s8..s9: subtract, third threshold ---------------------
	cf_t lo_s8, lo_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s8.r22 <= sat_sub(cf_s[ML-1].r22, pf2);
			lo_s8.r23 <= sat_sub(cf_s[ML-1].r23, pf3);
			lo_s8.q12 <= cf_s[ML-1].q12;
			lo_s8.q13 <= cf_s[ML-1].q13;
			lo_s8.q0  <= cf_s[ML-1].q0;
			lo_s8.fl  <= cf_s[ML-1].fl;

			lo_s9.r22    <= lo_s8.r22;
			lo_s9.r23    <= lo_s8.r23;
			lo_s9.q12    <= lo_s8.q12;
			lo_s9.q13    <= lo_s8.q13;
			lo_s9.q0     <= lo_s8.q0;
			lo_s9.fl.nz0 <= lo_s8.fl.nz0;
			lo_s9.fl.nz1 <= lo_s8.fl.nz1;
			lo_s9.fl.nz2 <= near_zero(lo_s8.r22, eps_q);
		end
	end

	// ---------------- back-substitution: x2 ---------------------------------
	v_t  x2;
	ch_t ch_in;
	ch_t ch_s [DL];

	s3ls_div #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_div22 (
		.clk (clk),
		.en  (en),
		.num (lo_s9.r23),
		.den (lo_s9.r22),
		.quo (x2)
	);

	always_comb begin
		ch_in.q12 = lo_s9.q12;
		ch_in.q13 = lo_s9.q13;
		ch_in.q0  = lo_s9.q0;
		ch_in.fl  = lo_s9.fl;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ch_s[0] <= ch_in;
			for (int k = 1; k < DL; k++) begin
				ch_s[k] <= ch_s[k-1];
			end
		end
	end

	// ---------------- back-substitution: x1 and partial x0 ------------------
	v_t  pi1, pi2;
	ci_t ci_in;
	ci_t ci_s [ML];
	bk_t bk_s10;

	s3ls_mul #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_mul_x2a (
		.clk  (clk),
		.en   (en),
		.a    (x2),
		.b    (ch_s[DL-1].q12),
		.prod (pi1)
	);

	s3ls_mul #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_mul_x2b (
		.clk  (clk),
		.en   (en),
		.a    (x2),
		.b    (ch_s[DL-1].q0[2]),
		.prod (pi2)
	);

	always_comb begin
		ci_in.x2  = x2;
		ci_in.q13 = ch_s[DL-1].q13;
		ci_in.q0  = ch_s[DL-1].q0;
		ci_in.fl  = ch_s[DL-1].fl;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ci_s[0] <= ci_in;
			for (int k = 1; k < ML; k++) begin
				ci_s[k] <= ci_s[k-1];
			end
			bk_s10.x2  <= ci_s[ML-1].x2;
			bk_s10.x1  <= sat_sub(ci_s[ML-1].q13, pi1);
			bk_s10.t   <= sat_sub(ci_s[ML-1].q0[3], pi2);
			bk_s10.q01 <= ci_s[ML-1].q0[1];
			bk_s10.fl  <= ci_s[ML-1].fl;
		end
	end

	// ---------------- back-substitution: x0, result -------------------------
	v_t  pj;
	bk_t cj_s [ML];
	logic ok;

	s3ls_mul #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_mul_x1 (
		.clk  (clk),
		.en   (en),
		.a    (bk_s10.x1),
		.b    (bk_s10.q01),
		.prod (pj)
	);

	assign ok = !(cj_s[ML-1].fl.nz0 || cj_s[ML-1].fl.nz1 || cj_s[ML-1].fl.nz2);

	always_ff @(posedge clk) begin
		if (en) begin
			cj_s[0] <= bk_s10;
			for (int k = 1; k < ML; k++) begin
				cj_s[k] <= cj_s[k-1];
			end
			res_s11.sol0   <= ok ? sat_sub(cj_s[ML-1].t, pj) : '0;
			res_s11.sol1   <= ok ? cj_s[ML-1].x1 : '0;
			res_s11.sol2   <= ok ? cj_s[ML-1].x2 : '0;
			res_s11.solved <= ok;
		end
	end
endmodule

/* rtl/s3ls_chk.sv */
// ----------------------------------------------------------------------------
// s3ls_chk
// Port-level checks for the solver, bound to the top level.
// ----------------------------------------------------------------------------
module s3ls_chk #(
	parameter int DATA_WIDTH = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [DATA_WIDTH-1:0] sol_0,
	input logic [DATA_WIDTH-1:0] sol_1,
	input logic [DATA_WIDTH-1:0] sol_2,
	input logic                  solved
);
	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({sol_0, sol_1, sol_2, solved}))
		else $error("result changed while stalled");

	// failure reports a zero solution
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !solved |-> sol_0 == '0 && sol_1 == '0 && sol_2 == '0)
		else $error("nonzero solution on failure");

	// input backpressure only comes from a full output stage
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");
endmodule

bind solve_3x3_linear_system s3ls_chk #(.DATA_WIDTH(DATA_WIDTH)) u_s3ls_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.sol_0     (out_ch.sol_0),
	.sol_1     (out_ch.sol_1),
	.sol_2     (out_ch.sol_2),
	.solved    (out_ch.solved)
);
